// ===== hw/rtl/bswa_pkg.sv =====
// ----------------------------------------------------------------------------
// bswa_pkg
// Shared types and constants for the band spectral weight accumulator.
// ----------------------------------------------------------------------------
package bswa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SUM_W     = 39;
	localparam int WG_W      = 63;
	localparam int NUM_W     = WG_W + FRAC_BITS + 30;
	localparam int DEN0_W    = 67;
	localparam int DLO_W     = 34;
	localparam int DEN_W     = 99;
	localparam int REM_W     = DEN_W + 1;
	localparam int QCNT_W    = 6;

	localparam logic [31:0]      PI_Q30  = 32'd3373259426;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam logic [1:0] CFG_CHEM_POT  = 2'd0;
	localparam logic [1:0] CFG_BROAD_FLR = 2'd1;
	localparam logic [1:0] CFG_UNIT_MODE = 2'd2;

	typedef struct packed {
		logic signed [31:0] frequency;
		logic signed [31:0] energy_real;
		logic signed [31:0] energy_imag;
		logic signed [31:0] weight_real;
		logic signed [31:0] weight_imag;
		logic               last_band;
	} band_t;

	typedef struct packed {
		logic [SUM_W-1:0] spectral_sum;
		logic             saturated;
	} result_t;

	typedef struct packed {
		logic [32:0] ud;
		logic [31:0] gamma;
		logic [31:0] w;
		logic        last;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SQR,
		F_ROOT,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DEN,
		B_PI,
		B_SUM,
		B_CMP,
		B_DIV,
		B_ACC
	} back_state_t;

endpackage

// ===== hw/rtl/bswa_front.sv =====
// ----------------------------------------------------------------------------
// bswa_front
// Accepts bands, clamps the width, forms the detuning and the weight magnitude.
// ----------------------------------------------------------------------------
module bswa_front import bswa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               band_valid,
	output logic               band_ready,
	input  band_t              band,
	input  logic signed [31:0] chem_pot,
	input  logic [30:0]        broad_floor,
	input  logic               unit_mode,
	output logic               push_valid,
	input  logic               push_ready,
	output job_t               push_data
);

	front_state_t state_q, state_d;

	logic [31:0] gamma_q;
	logic [32:0] ud_q;
	logic        last_q;
	logic [31:0] awr_q;
	logic [31:0] awi_q;
	logic [31:0] w_q;
	logic [63:0] rad_q;
	logic [63:0] root_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;

	logic signed [32:0] ei_c;
	logic signed [32:0] fneg_c;
	logic signed [32:0] eic_c;
	logic [32:0]        gneg_c;
	logic signed [33:0] d_c;
	logic [33:0]        dneg_c;
	logic [32:0]        ud_c;
	logic [31:0]        awr_c;
	logic [31:0]        awi_c;
	logic [63:0]        sqr_r;
	logic [63:0]        sqi_r;
	logic [63:0]        trial_c;
	logic [63:0]        rad_n;
	logic [63:0]        root_n;

	always_comb begin
		ei_c   = {band.energy_imag[31], band.energy_imag};
		fneg_c = $signed(33'd0 - {2'b00, broad_floor});
		eic_c  = (ei_c > fneg_c) ? fneg_c : ei_c;
		gneg_c = 33'd0 - 33'(eic_c);
		d_c = {{2{band.frequency[31]}}, band.frequency}
			- {{2{band.energy_real[31]}}, band.energy_real};
		if (!unit_mode) begin
			d_c = d_c + {{2{chem_pot[31]}}, chem_pot};
		end
		dneg_c = 34'd0 - 34'(d_c);
		ud_c   = d_c[33] ? dneg_c[32:0] : d_c[32:0];
		awr_c  = band.weight_real[31] ? 32'(~band.weight_real + 32'd1) : 32'(band.weight_real);
		awi_c  = band.weight_imag[31] ? 32'(~band.weight_imag + 32'd1) : 32'(band.weight_imag);
	end

	assign sqr_r = awr_q * awr_q;
	assign sqi_r = awi_q * awi_q;

	always_comb begin
		trial_c = root_q + bit_q;
		if (rad_q >= trial_c) begin
			rad_n  = rad_q - trial_c;
			root_n = (root_q >> 1) + bit_q;
		end else begin
			rad_n  = rad_q;
			root_n = root_q >> 1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (band_valid) begin
					state_d = unit_mode ? F_PUSH : F_SQR;
				end
			end
			F_SQR:  state_d = F_ROOT;
			F_ROOT: begin
				if (cnt_q == 5'd31) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		band_ready = (state_q == F_IDLE);
		push_valid = (state_q == F_PUSH);
		push_data  = '{ud: ud_q, gamma: gamma_q, w: w_q, last: last_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (band_valid) begin
					gamma_q <= gneg_c[31:0];
					ud_q    <= ud_c;
					last_q  <= band.last_band;
					awr_q   <= awr_c;
					awi_q   <= awi_c;
					w_q     <= 32'd1 << FRAC_BITS;
				end
			end
			F_SQR: begin
				rad_q  <= sqr_r + sqi_r;
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
				cnt_q  <= '0;
			end
			F_ROOT: begin
				rad_q  <= rad_n;
				root_q <= root_n;
				bit_q  <= bit_q >> 2;
				cnt_q  <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					w_q <= root_n[31:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/bswa_queue.sv =====
// ----------------------------------------------------------------------------
// bswa_queue
// Two-entry queue of prepared bands between front and back.
// ----------------------------------------------------------------------------
module bswa_queue import bswa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/bswa_back.sv =====
// ----------------------------------------------------------------------------
// bswa_back
// Forms the Lorentzian term by long division and keeps the saturating sum.
// ----------------------------------------------------------------------------
module bswa_back import bswa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pop_valid,
	output logic    pop_ready,
	input  job_t    pop_data,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	back_state_t state_q, state_d;

	logic [32:0]       ud_q;
	logic [31:0]       gamma_q;
	logic [31:0]       w_q;
	logic              last_q;
	logic [65:0]       ud2_q;
	logic [63:0]       g2_q;
	logic [WG_W-1:0]   wg_q;
	logic [DEN0_W-1:0] den0_q;
	logic [65:0]       plo_q;
	logic [64:0]       phi_q;
	logic [DEN_W-1:0]  den_q;
	logic [REM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  nlo_q;
	logic [SUM_W-1:0]  quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]  term_q;
	logic              term_clip_q;
	logic [SUM_W-1:0]  running_q;
	logic              clip_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [65:0]            ud2_c;
	logic [63:0]            g2_c;
	logic [63:0]            wg_c;
	logic [65:0]            plo_c;
	logic [64:0]            phi_c;
	logic [NUM_W-1:0]       num_c;
	logic [REM_W-1:0]       num_hi_c;
	logic [REM_W-1:0]       den_x_c;
	logic [REM_W-1:0]       trial_c;
	logic                   qbit_c;
	logic [REM_W-1:0]       rem_n;
	logic [SUM_W-1:0]       quo_n;
	logic [SUM_W:0]         sum_c;
	logic [SUM_W-1:0]       sum_sat_c;
	logic                   sum_clip_c;
	logic                   can_finish;

	assign ud2_c = ud_q * ud_q;
	assign g2_c  = gamma_q * gamma_q;
	assign wg_c  = w_q * gamma_q;
	assign plo_c = den0_q[DLO_W-1:0] * PI_Q30;
	assign phi_c = den0_q[DEN0_W-1:DLO_W] * PI_Q30;

	always_comb begin
		num_c    = NUM_W'(wg_q) << (FRAC_BITS + 30);
		num_hi_c = REM_W'(num_c[NUM_W-1:SUM_W]);
		den_x_c  = REM_W'(den_q);
		trial_c  = {rem_q[REM_W-2:0], nlo_q[SUM_W-1]};
		qbit_c   = (trial_c >= den_x_c);
		rem_n    = qbit_c ? trial_c - den_x_c : trial_c;
		quo_n    = {quo_q[SUM_W-2:0], qbit_c};
		sum_c    = {1'b0, running_q} + {1'b0, term_q};
		sum_clip_c = sum_c[SUM_W];
		sum_sat_c  = sum_clip_c ? SUM_MAX : sum_c[SUM_W-1:0];
		can_finish = !last_q || !out_valid_q || result_ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					state_d = B_MUL;
				end
			end
			B_MUL: state_d = B_DEN;
			B_DEN: state_d = B_PI;
			B_PI:  state_d = B_SUM;
			B_SUM: state_d = B_CMP;
			B_CMP: begin
				if (gamma_q == 32'd0 || num_hi_c >= den_x_c) begin
					state_d = B_ACC;
				end else begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (cnt_q == QCNT_W'(SUM_W - 1)) begin
					state_d = B_ACC;
				end
			end
			B_ACC: begin
				if (can_finish) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop_ready    = (state_q == B_IDLE);
		result_valid = out_valid_q;
		result       = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			running_q   <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == B_ACC && can_finish) begin
				if (last_q) begin
					out_valid_q <= 1'b1;
					running_q   <= '0;
					clip_q      <= 1'b0;
				end else begin
					running_q <= sum_sat_c;
					clip_q    <= clip_q | term_clip_q | sum_clip_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					ud_q    <= pop_data.ud;
					gamma_q <= pop_data.gamma;
					w_q     <= pop_data.w;
					last_q  <= pop_data.last;
				end
			end
			B_MUL: begin
				ud2_q <= ud2_c;
				g2_q  <= g2_c;
				wg_q  <= wg_c[WG_W-1:0];
			end
			B_DEN: den0_q <= DEN0_W'(ud2_q) + DEN0_W'(g2_q);
			B_PI: begin
				plo_q <= plo_c;
				phi_q <= phi_c;
			end
			B_SUM: den_q <= DEN_W'(plo_q) + (DEN_W'(phi_q) << DLO_W);
			B_CMP: begin
				term_clip_q <= 1'b0;
				if (gamma_q == 32'd0) begin
					term_q <= '0;
				end else if (num_hi_c >= den_x_c) begin
					term_q      <= SUM_MAX;
					term_clip_q <= 1'b1;
				end else begin
					rem_q <= num_hi_c;
					nlo_q <= num_c[SUM_W-1:0];
					quo_q <= '0;
					cnt_q <= '0;
				end
			end
			B_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				nlo_q <= nlo_q << 1;
				cnt_q <= cnt_q + QCNT_W'(1);
				if (cnt_q == QCNT_W'(SUM_W - 1)) begin
					term_q <= quo_n;
				end
			end
			B_ACC: begin
				if (can_finish && last_q) begin
					out_q.spectral_sum <= sum_sat_c;
					out_q.saturated    <= clip_q | term_clip_q | sum_clip_c;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/band_spectral_weight_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// band_spectral_weight_accumulator_top
// Sums Lorentzian spectral weight over a stream of bands.
// ----------------------------------------------------------------------------
// One band request enters on band_valid/band_ready. The front clamps the
// imaginary energy, forms the detuning and, in weighted mode, the weight
// magnitude by a 32-step square root; it then hands the band to a two-entry
// queue. The back squares, scales by pi and runs a 39-step long division,
// then adds the term to a saturating 39-bit sum.
// In unit-weight mode the front skips the square root. The back's long
// division sets the sustained rate of bands, the front overlapping with it.
// A band marked last places the sum and the clip flag in the output register,
// offered on result_valid/result_ready, and clears the sum. If the receiver
// stalls, the back holds on the next last band until the register is free;
// the queue and front keep taking bands meanwhile until the queue is full.
// Reset clears the sum, the clip flag, the queue and both controllers, and
// loads mu = 0, floor = 66, unit-weight mode off. Write registers while idle.
// ----------------------------------------------------------------------------
module band_spectral_weight_accumulator_top import bswa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        band_valid,
	output logic        band_ready,
	input  band_t       band,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [31:0] chem_pot_q;
	logic [30:0]        broad_floor_q;
	logic               unit_mode_q;

	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chem_pot_q    <= '0;
			broad_floor_q <= 31'd66;
			unit_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHEM_POT:  chem_pot_q    <= cfg_data;
				CFG_BROAD_FLR: broad_floor_q <= cfg_data[30:0];
				CFG_UNIT_MODE: unit_mode_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	bswa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.band_valid  (band_valid),
		.band_ready  (band_ready),
		.band        (band),
		.chem_pot    (chem_pot_q),
		.broad_floor (broad_floor_q),
		.unit_mode   (unit_mode_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	bswa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bswa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== test/band_spectral_weight_accumulator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_spectral_weight_accumulator_checker
// Watches the band, result and register ports, predicts each emitted spectral
// sum from its own copy of the registers and running sum, and counts
// mismatches, unexpected results and sums still owed at the end.
// ----------------------------------------------------------------------------
module band_spectral_weight_accumulator_checker import bswa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        band_valid,
	input  logic        band_ready,
	input  band_t       band,
	input  logic        result_valid,
	input  logic        result_ready,
	input  result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          owed,
	output int          fails
);

	logic signed [63:0] mu;
	logic [30:0]        floor_q;
	logic               unit_mode;
	logic [SUM_W-1:0]   acc_sum;
	logic               acc_clip;
	result_t            owed_sums[$];

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic add_band(input band_t b);
		logic signed [63:0] ei;
		logic signed [63:0] wr;
		logic signed [63:0] wi;
		logic signed [63:0] d;
		logic signed [63:0] floor_neg;
		logic [63:0]        gam;
		logic [63:0]        w;
		logic [63:0]        ud;
		logic [63:0]        awr;
		logic [63:0]        awi;
		logic [127:0]       num;
		logic [127:0]       den;
		logic [127:0]       q;
		logic [127:0]       ud_w;
		logic [127:0]       gam_w;
		logic [SUM_W-1:0]   term;
		logic [SUM_W:0]     s;
		result_t            r;
		ei = b.energy_imag;
		wr = b.weight_real;
		wi = b.weight_imag;
		floor_neg = -$signed({33'd0, floor_q});
		if (ei > floor_neg)
			ei = floor_neg;
		gam = -ei;
		if (unit_mode) begin
			w = 64'd1 << FRAC_BITS;
			d = 64'(b.frequency) - 64'(b.energy_real);
		end else begin
			awr = wr < 0 ? -wr : wr;
			awi = wi < 0 ? -wi : wi;
			w = root_floor(awr * awr + awi * awi);
			d = 64'(b.frequency) + mu - 64'(b.energy_real);
		end
		ud = d < 0 ? -d : d;
		term = 0;
		if (gam != 0) begin
			num = 128'(w * gam) << (FRAC_BITS + 30);
			ud_w = ud;
			gam_w = gam;
			den = (ud_w * ud_w + gam_w * gam_w) * 128'(PI_Q30);
			q = num / den;
			if (q > 128'(SUM_MAX)) begin
				term = SUM_MAX;
				acc_clip = 1'b1;
			end else begin
				term = q[SUM_W-1:0];
			end
		end
		s = {1'b0, acc_sum} + {1'b0, term};
		if (s > {1'b0, SUM_MAX}) begin
			s = {1'b0, SUM_MAX};
			acc_clip = 1'b1;
		end
		acc_sum = s[SUM_W-1:0];
		if (b.last_band) begin
			r.spectral_sum = acc_sum;
			r.saturated = acc_clip;
			owed_sums.push_back(r);
			acc_sum = 0;
			acc_clip = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			mu = 0;
			floor_q = 31'd66;
			unit_mode = 1'b0;
			acc_sum = 0;
			acc_clip = 1'b0;
			fails = 0;
			owed_sums.delete();
			owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHEM_POT:  mu = $signed(cfg_data);
					CFG_BROAD_FLR: floor_q = cfg_data[30:0];
					CFG_UNIT_MODE: unit_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (band_valid && band_ready)
				add_band(band);
			if (result_valid && result_ready) begin
				if (owed_sums.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: sum %0d sat %0b",
							result.spectral_sum, result.saturated);
				end else begin
					e = owed_sums.pop_front();
					if (e.spectral_sum !== result.spectral_sum ||
							e.saturated !== result.saturated) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: expected sum %0d sat %0b, got sum %0d sat %0b",
								e.spectral_sum, e.saturated,
								result.spectral_sum, result.saturated);
					end
				end
			end
			owed = owed_sums.size();
		end
	end

endmodule

// ===== test/band_spectral_weight_accumulator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_spectral_weight_accumulator_top_tb
// Drives band requests through directed extremes and random runs of bands
// under several register settings and idling patterns, including a long
// receiver hold-off; the checker compares every emitted spectral sum.
// ----------------------------------------------------------------------------
module band_spectral_weight_accumulator_top_tb;
	import bswa_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int QUIET_CYCLES = 300;
	localparam int STALL_LIMIT  = 20000;

	logic        clk;
	logic        arst_n;
	logic        band_valid;
	logic        band_ready;
	band_t       band;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          owed;
	int          fails;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;
	int          quiet;

	band_spectral_weight_accumulator_top DUT (.*);

	band_spectral_weight_accumulator_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_ready <= 1'b0;
			hold_cycles--;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((band_valid && band_ready) || (result_valid && result_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("[band_spectral_weight_accumulator_top] ERROR");
			$finish;
		end
	end

	task automatic send_band(input band_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			band_valid <= 1'b0;
			@(negedge clk);
		end
		band <= b;
		band_valid <= 1'b1;
		do @(posedge clk); while (!band_ready);
		@(negedge clk);
	endtask

	task automatic drain;
		band_valid <= 1'b0;
		while (owed != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick(input int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 1 << 20) - (1 << 19);
			2: return -$urandom_range(1, 1 << 18);
			default: return $urandom_range(0, 1 << 18);
		endcase
	endfunction

	function automatic band_t make_band(input logic [31:0] freq, input logic last);
		band_t b;
		b.frequency = freq;
		b.energy_real = pick($urandom_range(9) == 0 ? 0 : 1);
		b.energy_imag = pick($urandom_range(9) == 0 ? 0 : 2);
		b.weight_real = pick($urandom_range(9) == 0 ? 0 : 1);
		b.weight_imag = pick($urandom_range(9) == 0 ? 0 : 3);
		b.last_band = last;
		return b;
	endfunction

	task automatic random_bands(input int count);
		int          run_len;
		logic [31:0] freq;
		band_t       b;
		while (count > 0) begin
			run_len = $urandom_range(1, 8);
			freq = pick($urandom_range(9) == 0 ? 0 : 1);
			for (int i = 0; i < run_len; i++) begin
				b = make_band(freq, i == run_len - 1);
				if ($urandom_range(19) == 0)
					b = {$urandom, $urandom, $urandom, $urandom, $urandom,
						1'($urandom)};
				send_band(b);
				count--;
			end
		end
		b = make_band(freq, 1'b1);
		send_band(b);
	endtask

	task automatic directed_bands;
		band_t b;
		b = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 1'b1};
		send_band(b);
		b = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 1'b1};
		send_band(b);
		b = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b1};
		send_band(b);
		// clip the term on a narrow resonance, then overflow the sum
		b = '{32'h0, 32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0};
		send_band(b);
		send_band(b);
		b.last_band = 1'b1;
		send_band(b);
		b = '{32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000,
			32'h0, 1'b0};
		send_band(b);
		b.energy_imag = 32'h0;
		b.last_band = 1'b1;
		send_band(b);
		b = '{32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 1'b1};
		send_band(b);
	endtask

	initial begin
		arst_n = 1'b0;
		band_valid = 1'b0;
		band = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CHEM_POT;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		quiet = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_bands();
		drain();
		write_reg(CFG_BROAD_FLR, 32'd0);
		write_reg(CFG_UNUSED, 32'hffff_ffff);
		directed_bands();
		random_bands(100);
		drain();

		write_reg(CFG_CHEM_POT, 32'h8000_0000);
		write_reg(CFG_BROAD_FLR, 32'h7fff_ffff);
		send_idle_pct = 59;
		directed_bands();
		random_bands(200);
		drain();

		write_reg(CFG_CHEM_POT, 32'h7fff_ffff);
		write_reg(CFG_BROAD_FLR, 32'd66);
		write_reg(CFG_UNIT_MODE, 32'd1);
		send_idle_pct = 0;
		recv_stall_pct = 59;
		random_bands(400);
		drain();

		write_reg(CFG_CHEM_POT, 32'h0003_0000);
		write_reg(CFG_BROAD_FLR, 32'd1);
		write_reg(CFG_UNIT_MODE, 32'd0);
		send_idle_pct = 13;
		recv_stall_pct = 13;
		random_bands(400);
		drain();

		write_reg(CFG_CHEM_POT, $urandom);
		write_reg(CFG_BROAD_FLR, $urandom_range(0, 4000));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 3000;
		random_bands(400);
		drain();

		write_reg(CFG_UNIT_MODE, 32'd1);
		send_idle_pct = 59;
		recv_stall_pct = 59;
		random_bands(400);
		drain();

		if (fails == 0 && owed == 0)
			$display("[band_spectral_weight_accumulator_top] OK");
		else
			$display("[band_spectral_weight_accumulator_top] ERROR");
		$finish;
	end

endmodule
